@@ rtl/core/tnbm_pkg.sv @@
// Package for the tanh backpropagation neuron: field widths, codes, reset values,
// saturation helpers and the elaboration-time tanh table generator.
// Has no dependencies; imported by tanh_neuron_backprop_momentum.
package tnbm_pkg;

    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 8;
    localparam int VAL_W      = 16;
    localparam int RKIND_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = SLOT_W + 2 * VAL_W;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = SLOT_W + VAL_W;
    localparam int M_TUSER_W = RKIND_W;

    localparam int SLOT_RANGE = 2 ** SLOT_W;

    localparam int ACC_W     = 40;
    localparam int ACC_SUM_W = ACC_W + 1;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DERIV_W   = 19;
    localparam int FRAC_W    = 12;
    localparam int HD_SPLIT  = 20;
    localparam int UPD_SHIFT = 28;

    localparam longint DERIV_ONE = 4096;
    localparam longint UPD_ROUND = 64'sd1 <<< (UPD_SHIFT - 1);

    localparam int MAX_INPUTS_DEF = 256;
    localparam int TANH_DEPTH_DEF = 1024;

    localparam logic [CFG_DATA_W-1:0] LR_RESET  = 16'd9830;
    localparam logic [CFG_DATA_W-1:0] MOM_RESET = 16'd32768;

    localparam int TAYLOR_TERMS = 24;
    localparam int SQUARINGS    = 4;
    localparam int EXP_FRAC     = 30;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD      = 3'd0,
        KIND_FORWARD   = 3'd1,
        KIND_OUT_DELTA = 3'd2,
        KIND_HID_DELTA = 3'd3,
        KIND_UPDATE    = 3'd4
    } kind_t;

    typedef enum logic [RKIND_W-1:0] {
        RES_OUTPUT = 2'd0,
        RES_DELTA  = 2'd1,
        RES_WEIGHT = 2'd2
    } rkind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_MOMENTUM      = 2'd1
    } cfg_idx_t;

    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_SUM_W-1:0] v);
        if (v[ACC_SUM_W-1] != v[ACC_W-1]) begin
            return v[ACC_SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return v[ACC_W-1:0];
    endfunction

    // Shift-subtract divider, evaluated only while building constant tables.
    function automatic logic [63:0] elab_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          b;
        r = '0;
        q = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table entry: tanh at the bin center, via (1 - E) / (1 + E), E = exp(-2|c|) in Q2.30.
    function automatic logic signed [VAL_W-1:0] tanh_entry(input logic [31:0] idx,
                                                          input logic [31:0] depth);
        logic [63:0] centre;
        logic [63:0] mag;
        logic [63:0] z;
        logic [63:0] one;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic        is_neg;
        int          k;
        centre = elab_udiv((({32'd0, idx} << 1) | 64'd1) << 16, {32'd0, depth} << 1);
        is_neg = centre < 64'd32768;
        mag    = is_neg ? 64'd32768 - centre : centre - 64'd32768;
        z      = mag << 15;
        one    = 64'd1 << EXP_FRAC;
        pos    = one;
        neg    = '0;
        term   = one;
        for (k = 1; k <= TAYLOR_TERMS; k++) begin
            term = elab_udiv((term * z) >> EXP_FRAC, 64'(k));
            if (k[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        e = (pos > neg) ? pos - neg : '0;
        for (k = 0; k < SQUARINGS; k++) begin
            e = (e * e + (64'd1 << (EXP_FRAC - 1))) >> EXP_FRAC;
        end
        if (e > one) begin
            e = one;
        end
        num = ((one - e) << 13) + (one + e);
        den = (one + e) << 1;
        q   = elab_udiv(num, den);
        return is_neg ? VAL_W'(64'd0 - q) : VAL_W'(q);
    endfunction

endpackage

@@ rtl/core/tanh_neuron_backprop_momentum.sv @@
// Top level of the tanh backpropagation neuron with momentum, Q3.12 fixed point.
// Depends on tnbm_pkg for widths, codes, saturation helpers and the tanh table.
// A load completes in S_IDLE; other kinds run S_MUL and their own states to S_EMIT,
// which waits for m_tready, but a forward or hidden term without last returns from
// S_ACC. New transactions are taken only in S_IDLE, set by the single shared 33x20
// multiplier and its sequencer. Reset restores the registers and clears the
// accumulator, output and delta; weight and change stores hold nothing until loaded.
module tanh_neuron_backprop_momentum
    import tnbm_pkg::*;
#(
    parameter int MAX_INPUTS       = MAX_INPUTS_DEF,
    parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // slot, operand, term_weight
    input  logic [S_TUSER_W-1:0]  s_tuser,   // kind
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // result_slot, result_value
    output logic [M_TUSER_W-1:0]  m_tuser,   // result_kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_INPUTS);
    localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH);

    typedef logic signed [VAL_W-1:0] tanh_rom_t [TANH_TABLE_DEPTH];
    typedef logic [ADDR_W-1:0] slot_map_t [SLOT_RANGE];

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t r;
        int        i;
        for (i = 0; i < TANH_TABLE_DEPTH; i++) begin
            r[i] = tanh_entry(32'(i), 32'(TANH_TABLE_DEPTH));
        end
        return r;
    endfunction

    function automatic slot_map_t build_slot_map();
        slot_map_t m;
        int        i;
        for (i = 0; i < SLOT_RANGE; i++) begin
            m[i] = ADDR_W'(i % MAX_INPUTS);
        end
        return m;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();
    localparam slot_map_t SLOT_MAP = build_slot_map();

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FWD_IDX,
        S_FWD_ROM,
        S_FWD_SQ,
        S_FWD_DER,
        S_OD_FIN,
        S_HD_LO,
        S_HD_HI,
        S_HD_FIN,
        S_UP_ETA,
        S_UP_MOM,
        S_UP_CHG,
        S_UP_WGT,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    kind_t                      kind_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic signed [VAL_W-1:0]    opnd_reg;
    logic signed [VAL_W-1:0]    tw_reg;
    logic                       last_reg;
    logic [2*VAL_W-1:0]         store_q_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   hold_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [VAL_W-1:0]    out_reg;
    logic signed [DERIV_W-1:0]  deriv_reg;
    logic signed [VAL_W-1:0]    delta_reg;
    logic signed [VAL_W-1:0]    ch_reg;
    logic signed [VAL_W-1:0]    rom_q_reg;
    rkind_t                     res_kind_reg;
    logic signed [VAL_W-1:0]    res_value_reg;
    logic                       m_valid_reg;
    rkind_t                     m_kind_reg;
    logic [SLOT_W-1:0]          m_slot_reg;
    logic signed [VAL_W-1:0]    m_value_reg;
    logic [CFG_DATA_W-1:0]      eta_reg;
    logic [CFG_DATA_W-1:0]      alpha_reg;

    logic [2*VAL_W-1:0]         store_mem [MAX_INPUTS];

    logic                       in_accept;
    kind_t                      in_kind;
    logic [SLOT_W-1:0]          in_slot;
    logic signed [VAL_W-1:0]    in_opnd;
    logic signed [VAL_W-1:0]    in_tw;
    logic [ADDR_W-1:0]          in_addr;

    logic                       store_we;
    logic [ADDR_W-1:0]          store_waddr;
    logic [2*VAL_W-1:0]         store_wdata;
    logic signed [VAL_W-1:0]    store_weight;
    logic signed [VAL_W-1:0]    store_change;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    logic signed [2*VAL_W-1:0]  term_prod;
    logic signed [MUL_A_W-1:0]  eta_prod;
    logic signed [ACC_W-HD_SPLIT-1:0] acc_hi;
    logic signed [VAL_W-1:0]    fwd_sum;
    logic [VAL_W-1:0]           tanh_addr;

    logic signed [ACC_W-1:0]    acc_next;
    logic signed [DERIV_W-1:0]  deriv_next;
    logic signed [VAL_W-1:0]    od_delta_next;
    logic signed [VAL_W-1:0]    hd_delta_next;
    logic signed [VAL_W-1:0]    ch_next;
    logic signed [VAL_W-1:0]    wgt_next;

    assign in_kind   = kind_t'(s_tuser);
    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_opnd   = s_tdata[SLOT_W +: VAL_W];
    assign in_tw     = s_tdata[SLOT_W+VAL_W +: VAL_W];
    assign in_addr   = SLOT_MAP[in_slot];
    assign in_accept = s_tvalid && s_tready;

    assign store_weight = store_q_reg[VAL_W-1:0];
    assign store_change = store_q_reg[2*VAL_W-1:VAL_W];

    always_comb begin
        if (state_reg == S_UP_WGT) begin
            store_we    = 1'b1;
            store_waddr = addr_reg;
            store_wdata = {ch_reg, wgt_next};
        end else begin
            store_we    = in_accept && (in_kind == KIND_LOAD);
            store_waddr = in_addr;
            store_wdata = {{VAL_W{1'b0}}, in_opnd};
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (in_accept) begin
            store_q_reg <= store_mem[in_addr];
        end
    end

    assign term_prod = prod_reg[2*VAL_W-1:0];
    assign eta_prod  = prod_reg[MUL_A_W-1:0];
    assign acc_hi    = acc_reg[ACC_W-1:HD_SPLIT];
    assign fwd_sum   = sat16(64'(acc_reg) >>> FRAC_W);
    assign tanh_addr = {~fwd_sum[VAL_W-1], fwd_sum[VAL_W-2:0]};

    assign acc_next      = sat_acc(ACC_SUM_W'(acc_reg) + ACC_SUM_W'(term_prod));
    assign deriv_next    = DERIV_W'(64'(DERIV_ONE) - (64'(prod_reg) >>> FRAC_W));
    assign od_delta_next = sat16(64'(prod_reg) >>> FRAC_W);
    assign hd_delta_next = sat16(((64'(prod_reg) <<< HD_SPLIT) + 64'(hold_reg))
                                 >>> (2 * FRAC_W));
    assign ch_next       = sat16(((64'(prod_reg) <<< FRAC_W) - 64'(hold_reg) + UPD_ROUND)
                                 >>> UPD_SHIFT);
    assign wgt_next      = sat16(64'(store_weight) + 64'(ch_reg));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL: begin
                unique case (kind_reg)
                    KIND_FORWARD: begin
                        mul_a = MUL_A_W'(opnd_reg);
                        mul_b = MUL_B_W'(store_weight);
                    end
                    KIND_HID_DELTA: begin
                        mul_a = MUL_A_W'(opnd_reg);
                        mul_b = MUL_B_W'(tw_reg);
                    end
                    KIND_OUT_DELTA: begin
                        mul_a = MUL_A_W'(out_reg) - MUL_A_W'(opnd_reg);
                        mul_b = MUL_B_W'(deriv_reg);
                    end
                    KIND_UPDATE: begin
                        mul_a = MUL_A_W'(opnd_reg);
                        mul_b = MUL_B_W'(delta_reg);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_FWD_IDX: begin
                mul_a = MUL_A_W'(tanh_addr);
                mul_b = MUL_B_W'(TANH_TABLE_DEPTH);
            end
            S_FWD_SQ: begin
                mul_a = MUL_A_W'(rom_q_reg);
                mul_b = MUL_B_W'(rom_q_reg);
            end
            S_HD_LO: begin
                mul_a = MUL_A_W'(acc_reg[HD_SPLIT-1:0]);
                mul_b = MUL_B_W'(deriv_reg);
            end
            S_HD_HI: begin
                mul_a = MUL_A_W'(acc_hi);
                mul_b = MUL_B_W'(deriv_reg);
            end
            S_UP_ETA: begin
                mul_a = eta_prod;
                mul_b = MUL_B_W'(eta_reg);
            end
            S_UP_MOM: begin
                mul_a = MUL_A_W'(store_change);
                mul_b = MUL_B_W'(alpha_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            eta_reg     <= LR_RESET;
            alpha_reg   <= MOM_RESET;
            acc_reg     <= '0;
            out_reg     <= '0;
            delta_reg   <= '0;
            deriv_reg   <= DERIV_W'(DERIV_ONE);
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LEARNING_RATE: eta_reg   <= cfg_data;
                    CFG_MOMENTUM:      alpha_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            prod_reg <= mul_p;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        kind_reg <= in_kind;
                        slot_reg <= in_slot;
                        addr_reg <= in_addr;
                        opnd_reg <= in_opnd;
                        tw_reg   <= in_tw;
                        last_reg <= s_tlast;
                        unique case (in_kind)
                            KIND_FORWARD, KIND_OUT_DELTA, KIND_HID_DELTA, KIND_UPDATE: begin
                                state_reg <= S_MUL;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: begin
                    unique case (kind_reg)
                        KIND_FORWARD, KIND_HID_DELTA: state_reg <= S_ACC;
                        KIND_OUT_DELTA:               state_reg <= S_OD_FIN;
                        KIND_UPDATE:                  state_reg <= S_UP_ETA;
                        default:                      state_reg <= S_IDLE;
                    endcase
                end
                S_ACC: begin
                    acc_reg <= acc_next;
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (kind_reg == KIND_FORWARD) begin
                        state_reg <= S_FWD_IDX;
                    end else begin
                        state_reg <= S_HD_LO;
                    end
                end
                S_FWD_IDX: begin
                    acc_reg   <= '0;
                    state_reg <= S_FWD_ROM;
                end
                S_FWD_ROM: begin
                    rom_q_reg <= TANH_ROM[prod_reg[VAL_W +: IDX_W]];
                    state_reg <= S_FWD_SQ;
                end
                S_FWD_SQ: begin
                    out_reg       <= rom_q_reg;
                    res_value_reg <= rom_q_reg;
                    res_kind_reg  <= RES_OUTPUT;
                    state_reg     <= S_FWD_DER;
                end
                S_FWD_DER: begin
                    deriv_reg <= deriv_next;
                    state_reg <= S_EMIT;
                end
                S_OD_FIN: begin
                    delta_reg     <= od_delta_next;
                    res_value_reg <= od_delta_next;
                    res_kind_reg  <= RES_DELTA;
                    state_reg     <= S_EMIT;
                end
                S_HD_LO: begin
                    state_reg <= S_HD_HI;
                end
                S_HD_HI: begin
                    hold_reg  <= prod_reg;
                    state_reg <= S_HD_FIN;
                end
                S_HD_FIN: begin
                    delta_reg     <= hd_delta_next;
                    res_value_reg <= hd_delta_next;
                    res_kind_reg  <= RES_DELTA;
                    acc_reg       <= '0;
                    state_reg     <= S_EMIT;
                end
                S_UP_ETA: begin
                    state_reg <= S_UP_MOM;
                end
                S_UP_MOM: begin
                    hold_reg  <= prod_reg;
                    state_reg <= S_UP_CHG;
                end
                S_UP_CHG: begin
                    ch_reg    <= ch_next;
                    state_reg <= S_UP_WGT;
                end
                S_UP_WGT: begin
                    res_value_reg <= wgt_next;
                    res_kind_reg  <= RES_WEIGHT;
                    state_reg     <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= res_kind_reg;
                        m_value_reg <= res_value_reg;
                        m_slot_reg  <= (res_kind_reg == RES_WEIGHT) ? slot_reg : '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_value_reg, m_slot_reg};
    assign m_tuser   = m_kind_reg;

    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("Result register loaded outside the emit state.");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FWD_IDX) |=> (acc_reg == '0))
        else $error("Accumulator not cleared after the final forward transaction.");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg != RES_WEIGHT)) |-> (m_slot_reg == '0))
        else $error("Output or delta result carries a nonzero slot.");

    a_deriv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !(deriv_reg > DERIV_W'(DERIV_ONE)))
        else $error("Tanh derivative exceeds one.");

endmodule

@@ verif/tb_tanh_neuron_backprop_momentum.sv @@
// Self-checking testbench for tanh_neuron_backprop_momentum: a directed stimulus table, then
// random training sequences under several learning-rate and momentum settings and saturating
// sums, checked with a fixed-point model or typed rows. Depends on tnbm_pkg and the RTL top.
module tb_tanh_neuron_backprop_momentum;
    timeunit 1ns;
    timeprecision 1ps;

    import tnbm_pkg::*;

    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     PHASE_ITEMS  = 190;
    localparam int     SAT_TERMS    = 520;
    localparam int     NUM_PHASES   = 6;
    localparam int     LUT_DEPTH    = TANH_DEPTH_DEF;
    localparam int     NUM_SLOTS    = MAX_INPUTS_DEF;
    localparam longint ACC_HI       = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_LO       = -(64'sd1 <<< (ACC_W - 1));

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_UPDATE + 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_HOLD
    } ready_mode_t;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] operand;
        logic signed [VAL_W-1:0] term_w;
        logic                    last;
    } neuron_item_t;

    typedef struct {
        rkind_t                  kind;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] value;
    } neuron_result_t;

    typedef struct {
        neuron_item_t   item;
        bit             typed;
        neuron_result_t want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // slot, operand, term_weight
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // kind
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // result_slot, result_value
    logic [M_TUSER_W-1:0]  m_tuser;          // result_kind
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    tanh_neuron_backprop_momentum uut (.*);

    logic signed [VAL_W-1:0] tanh_lut   [LUT_DEPTH];
    logic signed [VAL_W-1:0] weight_mem [NUM_SLOTS];
    logic signed [VAL_W-1:0] change_mem [NUM_SLOTS];
    longint                  acc_model;
    logic signed [VAL_W-1:0] out_model;
    logic signed [VAL_W-1:0] delta_model;
    logic [CFG_DATA_W-1:0]   eta_model;
    logic [CFG_DATA_W-1:0]   alpha_model;

    neuron_result_t    expected_results [$];
    directed_row_t     directed_rows [$];
    logic [SLOT_W-1:0] loaded_slots [$];
    bit                slot_loaded [NUM_SLOTS];
    int                mismatch_count = 0;
    int                items_sent     = 0;
    int                burst_left     = 1;
    ready_mode_t       ready_mode     = READY_ALWAYS;
    int                ready_run      = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic signed [VAL_W-1:0] clip16(input longint v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end
        if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic longint clip_acc(input longint v);
        if (v > ACC_HI) begin
            return ACC_HI;
        end
        if (v < ACC_LO) begin
            return ACC_LO;
        end
        return v;
    endfunction

    // Bin-center tanh as (1 - E) / (1 + E), E = exp(-2|c|) built from a truncated series
    // of exp(-2|c|/16) in Q2.30 that is then squared four times.
    function automatic void build_tanh_lut();
        longint          c;
        longint unsigned mag, z, one, pos, neg, term, e, num, den, q;
        one = 64'd1 << 30;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            c    = ((2 * longint'(i) + 1) * 65536) / (2 * LUT_DEPTH) - 32768;
            mag  = (c < 0) ? -c : c;
            z    = mag << 15;
            pos  = one;
            neg  = 0;
            term = one;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * z) >> 30) / 64'(k);
                if (k % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            e = (pos > neg) ? pos - neg : 64'd0;
            repeat (4) e = (e * e + (64'd1 << 29)) >> 30;
            if (e > one) begin
                e = one;
            end
            num = ((one - e) << 13) + (one + e);
            den = (one + e) << 1;
            q   = num / den;
            tanh_lut[i] = (c < 0) ? VAL_W'(-longint'(q)) : VAL_W'(q);
        end
    endfunction

    function automatic bit predict_neuron(input neuron_item_t it, output neuron_result_t r);
        longint                  op, tw, w, old_ch, d, grad, mom;
        logic signed [VAL_W-1:0] sum16, chg;
        op     = it.operand;
        tw     = it.term_w;
        w      = weight_mem[it.slot];
        old_ch = change_mem[it.slot];
        d      = 4096 - ((longint'(out_model) * longint'(out_model)) >>> 12);
        r.kind  = RES_OUTPUT;
        r.slot  = '0;
        r.value = '0;
        case (it.kind)
            KIND_LOAD: begin
                weight_mem[it.slot] = it.operand;
                change_mem[it.slot] = '0;
                return 1'b0;
            end
            KIND_FORWARD: begin
                acc_model = clip_acc(acc_model + op * w);
                if (!it.last) begin
                    return 1'b0;
                end
                sum16     = clip16(acc_model >>> 12);
                acc_model = 0;
                out_model = tanh_lut[(longint'(sum16) + 32768) >>> 6];
                r.value   = out_model;
                return 1'b1;
            end
            KIND_OUT_DELTA: begin
                delta_model = clip16(((longint'(out_model) - op) * d) >>> 12);
            end
            KIND_HID_DELTA: begin
                acc_model = clip_acc(acc_model + op * tw);
                if (!it.last) begin
                    return 1'b0;
                end
                delta_model = clip16((acc_model * d) >>> 24);
                acc_model   = 0;
            end
            KIND_UPDATE: begin
                grad = -longint'(eta_model) * (op * longint'(delta_model));
                mom  = longint'(alpha_model) * old_ch * 4096;
                chg  = clip16((grad + mom + (64'sd1 <<< 27)) >>> 28);
                change_mem[it.slot] = chg;
                weight_mem[it.slot] = clip16(w + chg);
                r.kind  = RES_WEIGHT;
                r.slot  = it.slot;
                r.value = weight_mem[it.slot];
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
        r.kind  = RES_DELTA;
        r.value = delta_model;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic drive_item(input neuron_item_t it, input bit typed, input neuron_result_t want);
        neuron_result_t r;
        bit             has;
        int             gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.term_w, it.operand, it.slot};
        s_tuser  <= it.kind;
        s_tlast  <= it.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        has = predict_neuron(it, r);
        if (typed) begin
            expected_results.push_back(want);
        end else if (has) begin
            expected_results.push_back(r);
        end
        if (it.kind == KIND_LOAD && !slot_loaded[it.slot]) begin
            slot_loaded[it.slot] = 1'b1;
            loaded_slots.push_back(it.slot);
        end
        if (it.kind <= KIND_UPDATE) begin
            items_sent++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                             input logic signed [VAL_W-1:0] operand,
                             input logic signed [VAL_W-1:0] term_w, input logic last);
        neuron_item_t   it;
        neuron_result_t none;
        it   = '{kind, slot, operand, term_w, last};
        none = '{RES_OUTPUT, '0, '0};
        drive_item(it, 1'b0, none);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_LEARNING_RATE) begin
            eta_model = value;
        end else begin
            alpha_model = value;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Registers may only change once the neuron has drained every pending transaction.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_q();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = '0;
                    3:       v = 16'sd4096;
                    default: v = -16'sd4096;
                endcase
            end
            2, 3, 4: v = VAL_W'($urandom);
            default: v = VAL_W'(int'($urandom_range(0, 12000)) - 6000);
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_weight();
        if ($urandom_range(0, 9) < 7) begin
            return VAL_W'(int'($urandom_range(0, 6000)) - 3000);
        end
        return rand_q();
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Optional loads, one forward pass, one delta and a few weight updates, as training issues them.
    task automatic training_step();
        int n;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_item(KIND_LOAD, SLOT_W'($urandom), rand_weight(), VAL_W'($urandom), coin());
            end
        end
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            send_item(KIND_FORWARD, pick_slot(), rand_q(), VAL_W'($urandom), i == n - 1);
        end
        if (coin()) begin
            send_item(KIND_OUT_DELTA, SLOT_W'($urandom), rand_q(), VAL_W'($urandom), coin());
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(KIND_FORWARD, pick_slot(), rand_q(), VAL_W'($urandom), 1'b0);
                end
                send_item(KIND_HID_DELTA, SLOT_W'($urandom), rand_q(), rand_q(), i == n - 1);
            end
        end
        repeat ($urandom_range(1, 4)) begin
            send_item(KIND_UPDATE, pick_slot(), rand_q(), VAL_W'($urandom), coin());
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 4))
            0: send_item(KIND_W'($urandom_range(int'(KIND_SPARE_FIRST), int'(KIND_SPARE_LAST))),
                         SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), coin());
            1: send_item(KIND_OUT_DELTA, SLOT_W'($urandom), rand_q(), VAL_W'($urandom), coin());
            2: send_item(KIND_FORWARD, pick_slot(), rand_q(), VAL_W'($urandom), 1'b0);
            3: send_item(KIND_HID_DELTA, SLOT_W'($urandom), rand_q(), rand_q(), coin());
            default: send_item(KIND_UPDATE, pick_slot(), rand_q(), VAL_W'($urandom), coin());
        endcase
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) == 0) begin
                noise_item();
            end else begin
                training_step();
            end
        end
    endtask

    // Long sums that drive the shared accumulator into both saturation limits.
    task automatic saturate_runs();
        send_item(KIND_LOAD, 8'd200, 16'sh8000, '0, 1'b0);
        for (int i = 0; i <= SAT_TERMS; i++) begin
            send_item(KIND_HID_DELTA, SLOT_W'($urandom), 16'sh8000, 16'sh8000, i == SAT_TERMS);
        end
        for (int i = 0; i <= SAT_TERMS; i++) begin
            send_item(KIND_FORWARD, 8'd200, 16'sh7fff, VAL_W'($urandom), i == SAT_TERMS);
        end
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                           input logic signed [VAL_W-1:0] operand,
                           input logic signed [VAL_W-1:0] term_w, input logic last,
                           input bit typed = 1'b0, input rkind_t rkind = RES_OUTPUT,
                           input logic signed [VAL_W-1:0] rvalue = '0);
        directed_row_t row;
        row.item  = '{kind, slot, operand, term_w, last};
        row.typed = typed;
        row.want  = '{rkind, (rkind == RES_WEIGHT) ? slot : SLOT_W'(0), rvalue};
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        add_row(KIND_OUT_DELTA, 8'd0, 16'sd0, 16'sd0, 1'b0, 1'b1, RES_DELTA, 16'sd0);
        add_row(KIND_OUT_DELTA, 8'd0, 16'sh8000, 16'sd0, 1'b0, 1'b1, RES_DELTA, 16'sh7fff);
        add_row(KIND_OUT_DELTA, 8'd0, 16'sh7fff, 16'sd0, 1'b0, 1'b1, RES_DELTA, -16'sd32767);
        add_row(KIND_LOAD, 8'd0, 16'sh7fff, 16'sd0, 1'b0);
        add_row(KIND_LOAD, 8'd255, 16'sh8000, 16'sh7fff, 1'b0);
        add_row(KIND_LOAD, 8'd5, 16'sd4096, 16'sd0, 1'b0);
        add_row(KIND_UPDATE, 8'd5, 16'sd0, 16'sd0, 1'b0, 1'b1, RES_WEIGHT, 16'sd4096);
        add_row(KIND_FORWARD, 8'd0, 16'sh7fff, 16'sd0, 1'b0);
        add_row(KIND_FORWARD, 8'd0, 16'sh7fff, 16'sh8000, 1'b1);
        add_row(KIND_FORWARD, 8'd255, 16'sh7fff, 16'sd0, 1'b1);
        add_row(KIND_HID_DELTA, 8'd0, 16'sh8000, 16'sh8000, 1'b0);
        add_row(KIND_HID_DELTA, 8'd255, 16'sh7fff, 16'sh7fff, 1'b1);
        add_row(KIND_FORWARD, 8'd5, 16'sd4096, 16'sd0, 1'b0);
        add_row(KIND_HID_DELTA, 8'd0, 16'sd4096, 16'sd4096, 1'b1);
        add_row(KIND_OUT_DELTA, 8'd0, 16'sd0, 16'sd0, 1'b1);
        add_row(KIND_UPDATE, 8'd0, 16'sh8000, 16'sd0, 1'b1);
        add_row(KIND_UPDATE, 8'd0, 16'sh7fff, 16'sd0, 1'b0);
        add_row(KIND_UPDATE, 8'd255, 16'sh7fff, 16'sh7fff, 1'b0);
        add_row(KIND_SPARE_FIRST, 8'd0, 16'sh7fff, 16'sh7fff, 1'b1);
        add_row(KIND_SPARE_FIRST + 3'd1, 8'd255, 16'sh8000, 16'sh8000, 1'b1);
        add_row(KIND_SPARE_LAST, 8'd5, 16'sd4096, 16'sd4096, 1'b1);
        add_row(KIND_LOAD, 8'd0, 16'sd0, 16'sd0, 1'b1);
        add_row(KIND_FORWARD, 8'd0, 16'sh8000, 16'sd0, 1'b1);
        add_row(KIND_UPDATE, 8'd0, 16'sd0, 16'sd0, 1'b0, 1'b1, RES_WEIGHT, 16'sd0);
    endtask

    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_run  = (ready_mode == READY_HOLD) ? $urandom_range(1, 12) : $urandom_range(8, 60);
        end
        ready_run--;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_HALF:   m_tready <= coin();
            READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        neuron_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d slot %0d value %0d",
                                          m_tuser, m_tdata[SLOT_W-1:0],
                                          $signed(m_tdata[SLOT_W +: VAL_W])));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              m_tuser, want.kind));
                end
                if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                    report_mismatch($sformatf("result_slot %0d, expected %0d",
                                              m_tdata[SLOT_W-1:0], want.slot));
                end
                if (m_tdata[SLOT_W +: VAL_W] !== want.value) begin
                    report_mismatch($sformatf("result_value %0d, expected %0d",
                                              $signed(m_tdata[SLOT_W +: VAL_W]), want.value));
                end
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("** tanh_neuron_backprop_momentum: FAILED **");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] eta_plan   [NUM_PHASES];
        logic [CFG_DATA_W-1:0] alpha_plan [NUM_PHASES];
        eta_plan   = '{16'd0, 16'hffff, 16'hffff, 16'd0, CFG_DATA_W'($urandom), LR_RESET};
        alpha_plan = '{16'd0, 16'hffff, 16'd0, 16'hffff, CFG_DATA_W'($urandom), MOM_RESET};
        build_tanh_lut();
        acc_model   = 0;
        out_model   = '0;
        delta_model = '0;
        eta_model   = LR_RESET;
        alpha_model = MOM_RESET;
        build_directed();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end
        run_random(PHASE_ITEMS);
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(CFG_LEARNING_RATE, eta_plan[p]);
            write_reg(CFG_MOMENTUM, alpha_plan[p]);
            run_random(PHASE_ITEMS);
        end
        saturate_runs();
        settle();
        if (mismatch_count == 0) begin
            $display("** tanh_neuron_backprop_momentum: PASSED **");
        end else begin
            $display("** tanh_neuron_backprop_momentum: FAILED **");
        end
        $finish;
    end

endmodule
